// ----- hdl/pfe_pkg.sv -----
// Shared types, character constants and helper functions for the Playfair encryptor.
package pfe_pkg;

  // Geometry of the square and the alphabet.
  localparam int SIDE    = 5;
  localparam int CELLS   = 25;
  localparam int LETTERS = 26;

  // Characters used by the cipher.
  localparam logic [7:0] CHAR_A = 8'h61;
  localparam logic [7:0] CHAR_I = 8'h69;
  localparam logic [7:0] CHAR_J = 8'h6a;
  localparam logic [7:0] CHAR_X = 8'h78;
  localparam logic [7:0] CHAR_Z = 8'h7a;

  // Letter index of j, which never enters the square.
  localparam logic [4:0] J_INDEX = 5'd9;

  // Input opcodes.
  typedef enum logic [1:0] {
    OP_KEY   = 2'd0,
    OP_FINAL = 2'd1,
    OP_MSG   = 2'd2,
    OP_END   = 2'd3
  } op_t;

  // Work handed from the front end to the back end.
  typedef enum logic [1:0] {
    CMD_KEY   = 2'd0,
    CMD_FINAL = 2'd1,
    CMD_PAIR  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic       done;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] data;
    logic       second;
    logic       done;
  } result_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_FINAL  = 3'd1,
    S_EMIT_A = 3'd2,
    S_EMIT_B = 3'd3
  } back_state_t;

  // Step one place along a row or column, wrapping at the edge.
  function automatic logic [2:0] step_mod5(input logic [2:0] v);
    step_mod5 = (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
  endfunction

  // Row-major cell index of a row and column.
  function automatic logic [4:0] cell_index(input logic [2:0] row, input logic [2:0] col);
    cell_index = 5'(row) * 5'(SIDE) + 5'(col);
  endfunction

endpackage

// ----- hdl/pfe_front.sv -----
// Front end: classifies input beats, pairs message bytes and issues commands.
module pfe_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [1:0]    opcode,
  input  logic [7:0]    in_byte,
  input  logic          cmd_full,
  output logic          full,
  output logic          cmd_push,
  output pfe_pkg::cmd_t cmd_data
);
  import pfe_pkg::*;

  logic [7:0] pending_byte;
  logic       pending_valid;
  logic [7:0] pending_byte_next;
  logic       pending_valid_next;
  logic       accept;
  op_t        op;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;
  assign op     = op_t'(opcode);

  // Decide what each accepted beat turns into and how the pending byte moves.
  always_comb begin
    cmd_push           = 1'b0;
    cmd_data.kind      = CMD_PAIR;
    cmd_data.byte_a    = in_byte;
    cmd_data.byte_b    = CHAR_X;
    cmd_data.done      = 1'b0;
    pending_byte_next  = pending_byte;
    pending_valid_next = pending_valid;
    if (accept) begin
      case (op)
        OP_KEY: begin
          // Only lower-case letters build the key, and j counts as i.
          if (in_byte >= CHAR_A && in_byte <= CHAR_Z) begin
            cmd_push        = 1'b1;
            cmd_data.kind   = CMD_KEY;
            cmd_data.byte_a = (in_byte == CHAR_J) ? CHAR_I : in_byte;
          end
        end
        OP_FINAL: begin
          cmd_push      = 1'b1;
          cmd_data.kind = CMD_FINAL;
        end
        OP_MSG: begin
          if (!pending_valid) begin
            pending_byte_next  = in_byte;
            pending_valid_next = 1'b1;
          end else if (pending_byte == in_byte) begin
            // A doubled letter is split with x; the second copy stays pending.
            cmd_push = 1'b1;
          end else begin
            cmd_push           = 1'b1;
            cmd_data.byte_a    = pending_byte;
            cmd_data.byte_b    = in_byte;
            pending_valid_next = 1'b0;
          end
        end
        OP_END: begin
          // A lone byte at the end of the message is padded with x.
          if (pending_valid) begin
            cmd_push           = 1'b1;
            cmd_data.byte_a    = pending_byte;
            cmd_data.done      = 1'b1;
            pending_valid_next = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Pending byte of an incomplete pair.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_byte  <= 8'd0;
      pending_valid <= 1'b0;
    end else begin
      pending_byte  <= pending_byte_next;
      pending_valid <= pending_valid_next;
    end
  end

endmodule

// ----- hdl/pfe_cmd_queue.sv -----
// Two-entry command queue between the front end and the back end.
module pfe_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  pfe_pkg::cmd_t wr_data,
  input  logic          rd_en,
  output pfe_pkg::cmd_t rd_data,
  output logic          q_full,
  output logic          q_empty
);
  import pfe_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign rd_data = slots[rd_ptr];

  // Storage for queued commands.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

// ----- hdl/pfe_back.sv -----
// Back end: builds the square, encrypts pairs and queues the result beats.
module pfe_back (
  input  logic          clk,
  input  logic          rst,
  input  pfe_pkg::cmd_t cmd_head,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  output logic [7:0]    out_byte,
  output logic          second_of_pair,
  output logic          message_done,
  output logic          empty,
  input  logic          pop
);
  import pfe_pkg::*;

  logic [7:0]       key_square [CELLS];
  logic [LETTERS-1:0] letter_used;
  logic [4:0]       fill_count;
  logic [4:0]       letter;
  back_state_t      state;
  back_state_t      state_next;

  logic             place_en;
  logic [4:0]       place_idx;
  logic             place_ok;
  logic             latch_pair;

  logic [7:0]       byte_a;
  logic [7:0]       byte_b;
  logic             pair_done;
  logic [2:0]       row_a;
  logic [2:0]       col_a;
  logic [2:0]       row_b;
  logic [2:0]       col_b;
  logic             found_a;
  logic             found_b;

  logic [2:0]       hit_row_a;
  logic [2:0]       hit_col_a;
  logic [2:0]       hit_row_b;
  logic [2:0]       hit_col_b;
  logic             hit_a;
  logic             hit_b;

  logic             code_ok;
  logic [4:0]       idx_a;
  logic [4:0]       idx_b;
  logic [4:0]       rd_idx;
  logic [7:0]       sq_rd;

  result_t          res_slots [2];
  logic             res_wr;
  logic             res_rd;
  logic [1:0]       res_count;
  logic             res_full;
  logic             res_push;
  logic             res_pop;
  result_t          res_data;

  // Search the square for both bytes of the head command at once.
  always_comb begin
    hit_a     = 1'b0;
    hit_b     = 1'b0;
    hit_row_a = 3'd0;
    hit_col_a = 3'd0;
    hit_row_b = 3'd0;
    hit_col_b = 3'd0;
    for (int k = 0; k < CELLS; k++) begin
      if (key_square[k] == cmd_head.byte_a) begin
        hit_a     = 1'b1;
        hit_row_a = 3'(k / SIDE);
        hit_col_a = 3'(k % SIDE);
      end
      if (key_square[k] == cmd_head.byte_b) begin
        hit_b     = 1'b1;
        hit_row_b = 3'(k / SIDE);
        hit_col_b = 3'(k % SIDE);
      end
    end
  end

  // Cipher cells for the latched pair; same row wins over same column.
  always_comb begin
    code_ok = (fill_count == 5'(CELLS)) && found_a && found_b;
    if (row_a == row_b) begin
      idx_a = cell_index(row_a, step_mod5(col_a));
      idx_b = cell_index(row_b, step_mod5(col_b));
    end else if (col_a == col_b) begin
      idx_a = cell_index(step_mod5(row_a), col_a);
      idx_b = cell_index(step_mod5(row_b), col_b);
    end else begin
      idx_a = cell_index(row_a, col_b);
      idx_b = cell_index(row_b, col_a);
    end
    rd_idx = (state == S_EMIT_B) ? idx_b : idx_a;
    sq_rd  = key_square[rd_idx];
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (!cmd_empty) begin
          case (cmd_head.kind)
            CMD_FINAL: state_next = S_FINAL;
            CMD_PAIR:  state_next = S_EMIT_A;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_FINAL: begin
        if (letter == 5'(LETTERS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_EMIT_A: begin
        if (!res_full) begin
          state_next = S_EMIT_B;
        end
      end
      S_EMIT_B: begin
        if (!res_full) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    cmd_pop         = 1'b0;
    place_en        = 1'b0;
    place_idx       = letter;
    latch_pair      = 1'b0;
    res_push        = 1'b0;
    res_data.data   = code_ok ? sq_rd : byte_a;
    res_data.second = 1'b0;
    res_data.done   = 1'b0;
    case (state)
      S_IDLE: begin
        place_idx = 5'(cmd_head.byte_a - CHAR_A);
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          case (cmd_head.kind)
            CMD_KEY:  place_en   = 1'b1;
            CMD_PAIR: latch_pair = 1'b1;
            default:  ;
          endcase
        end
      end
      S_FINAL: begin
        place_en = (letter != J_INDEX);
      end
      S_EMIT_A: begin
        res_push = !res_full;
      end
      S_EMIT_B: begin
        res_push        = !res_full;
        res_data.data   = code_ok ? sq_rd : byte_b;
        res_data.second = 1'b1;
        res_data.done   = pair_done;
      end
      default: ;
    endcase
  end

  assign place_ok = place_en && !letter_used[place_idx] && (fill_count < 5'(CELLS));

  // Square contents are written once each, in fill order.
  always_ff @(posedge clk) begin
    if (place_ok) begin
      key_square[fill_count] <= CHAR_A + 8'(place_idx);
    end
  end

  // Control state: sequencer, fill tracking and the finalise letter counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      letter_used <= '0;
      fill_count  <= 5'd0;
      letter      <= 5'd0;
    end else begin
      state <= state_next;
      if (place_ok) begin
        letter_used[place_idx] <= 1'b1;
        fill_count             <= fill_count + 5'd1;
      end
      if (state == S_FINAL) begin
        letter <= letter + 5'd1;
      end else begin
        letter <= 5'd0;
      end
    end
  end

  // Latch the pair and where its bytes sit in the square.
  always_ff @(posedge clk) begin
    if (latch_pair) begin
      byte_a    <= cmd_head.byte_a;
      byte_b    <= cmd_head.byte_b;
      pair_done <= cmd_head.done;
      row_a     <= hit_row_a;
      col_a     <= hit_col_a;
      row_b     <= hit_row_b;
      col_b     <= hit_col_b;
      found_a   <= hit_a;
      found_b   <= hit_b;
    end
  end

  // Result queue: two beats, so a full pair waits while the receiver stalls.
  assign res_full       = (res_count == 2'd2);
  assign empty          = (res_count == 2'd0);
  assign res_pop        = pop && !empty;
  assign out_byte       = res_slots[res_rd].data;
  assign second_of_pair = res_slots[res_rd].second;
  assign message_done   = res_slots[res_rd].done;

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_slots[res_wr] <= res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr    <= 1'b0;
      res_rd    <= 1'b0;
      res_count <= 2'd0;
    end else begin
      if (res_push) begin
        res_wr <= ~res_wr;
      end
      if (res_pop) begin
        res_rd <= ~res_rd;
      end
      res_count <= res_count + 2'(res_push) - 2'(res_pop);
    end
  end

endmodule

// ----- hdl/playfair_cipher_encrypt.sv -----
// Top level of the Playfair encryptor: front end, command queue and back end.
//
// Input channel: a beat (opcode, in_byte) is taken when push is high and full is
// low. Opcode key byte adds a letter to the square, finalise appends the unused
// letters, message byte forms pairs, end of message pads a lone byte with x.
// Result channel: while empty is low the oldest result beat is on out_byte,
// second_of_pair and message_done; it is taken when pop is high.
// Each completed pair gives two beats; key beats and the first byte of a pair
// give none.
// A beat that completes a pair goes through the command queue, is latched by the
// back end and then gives its first and second result beats to the result queue.
// For a pair the back end makes one square search and then one step per result
// beat through the single square read port, each step waiting while the result
// queue is full, and takes no new command until both beats are queued. A finalise
// beat makes it take the command and then place one letter per cycle.
// Reset (rst, synchronous) empties both queues, clears the pending byte and
// the record of placed letters; the square itself is refilled by new keys.
// When the receiver stalls, two result beats are held, the back end waits,
// the two-entry command queue fills and full rises.
module playfair_cipher_encrypt (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] opcode,
  input  logic [7:0] in_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       second_of_pair,
  output logic       message_done
);
  import pfe_pkg::*;

  cmd_t cmd_in;
  cmd_t cmd_head;
  logic cmd_push;
  logic cmd_pop;
  logic cmd_full;
  logic cmd_empty;

  pfe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .opcode   (opcode),
    .in_byte  (in_byte),
    .cmd_full (cmd_full),
    .full     (full),
    .cmd_push (cmd_push),
    .cmd_data (cmd_in)
  );

  pfe_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .rd_en   (cmd_pop),
    .rd_data (cmd_head),
    .q_full  (cmd_full),
    .q_empty (cmd_empty)
  );

  pfe_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_head       (cmd_head),
    .cmd_empty      (cmd_empty),
    .cmd_pop        (cmd_pop),
    .out_byte       (out_byte),
    .second_of_pair (second_of_pair),
    .message_done   (message_done),
    .empty          (empty),
    .pop            (pop)
  );

endmodule
